// ===== hw/rtl/vscd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vscd_pkg - shared types and constants of the scene cut detector
// Field widths, stream record layouts and the scene length helper.
// ============================================================================
package vscd_pkg;

    localparam int SIZE_W     = 24;
    localparam int PTS_W      = 48;
    localparam int TIME_W     = 40;
    localparam int FRAME_W    = 24;
    localparam int SCENE_W    = 20;
    localparam int THR_W      = 32;
    localparam int SUM_W      = 48;
    localparam int MEAN_W     = 32;
    localparam int FRAC_W     = 8;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int STEP_W     = $clog2(DIVIDEND_W);
    localparam int OUT_PAD_W  = 4;

    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(19661);
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
    localparam logic [SCENE_W-1:0] SCENE_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // Input payload, first field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] frame_time_us;
        logic [PTS_W-1:0]  frame_pts;
        logic [SIZE_W-1:0] frame_size;
    } in_data_t;

    // Scene record payload, first field in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [MEAN_W-1:0]    mean_size_q8;
        logic [FRAME_W-1:0]   frames_in_scene;
        logic [TIME_W-1:0]    end_time_us;
        logic [TIME_W-1:0]    start_time_us;
        logic [PTS_W-1:0]     end_pts;
        logic [PTS_W-1:0]     start_pts;
        logic [FRAME_W-1:0]   final_frame;
        logic [FRAME_W-1:0]   first_frame;
        logic [SCENE_W-1:0]   scene_number;
    } scene_rec_t;

    localparam int IN_W  = $bits(in_data_t);
    localparam int OUT_W = $bits(scene_rec_t);

    // Frame count of a scene; falls back to one when last is below first or the span overflows the field
    function automatic logic [FRAME_W-1:0] scene_count(input logic [FRAME_W-1:0] last,
                                                       input logic [FRAME_W-1:0] first);
        logic [FRAME_W-1:0] span;
        span = last - first + FRAME_W'(1);
        if (last < first || span == '0) begin
            return FRAME_W'(1);
        end
        return span;
    endfunction

endpackage

// ===== hw/rtl/vscd_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vscd_div - serial restoring divider for the scene mean size
// One quotient bit per cycle; quotient saturates to the mean field width.
// ============================================================================
module vscd_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [vscd_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [vscd_pkg::FRAME_W-1:0]       divisor,
    output logic                               busy,
    output logic                               done,
    output logic [vscd_pkg::MEAN_W-1:0]        quotient
);
    import vscd_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [FRAME_W-1:0]    rem_reg;
    logic [FRAME_W-1:0]    dsr_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [FRAME_W:0]      shifted;
    logic [FRAME_W:0]      diff;
    logic                  fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    // Control: step counter, busy and done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[FRAME_W-1:0] : shifted[FRAME_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = (|quo_reg[DIVIDEND_W-1:MEAN_W]) ? '1 : quo_reg[MEAN_W-1:0];

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= LAST_STEP)
        else $error("divider step counter past the last step");

endmodule

// ===== hw/rtl/video_scene_cut_detector_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// video_scene_cut_detector_core - scene cut detector over frame records
// Sequencer with scene state, size-change compare and a shared divider.
// ============================================================================
// Usage:
//   The s_ channel carries one record per coded frame (size, pts, time in
//   tdata, key flag in tuser, end of stream in tlast). The m_ channel carries
//   one record per closed scene (tuser = stream done, tlast = last record
//   caused by that frame). cfg_we/cfg_wdata write the Q16.16 threshold; write
//   it only while the block is idle.
//   Throughput: one frame at a time. A frame that closes no scene steps
//   through the multiply, compare and tail states. Every scene record needs
//   a pass through the serial mean divider plus compare and sequencing; a
//   frame closes at most two scenes, on a cut and at end of stream.
//   Order: after the compare, a cut record goes through the divider and
//   push states; an end-of-stream record follows through the tail state.
//   s_tready is high only while the sequencer is idle.
//   Stall: records leave through an output register; a stalled receiver
//   holds the sequencer before the next record is pushed.
//   Reset: aresetn (synchronous, active low) clears the scene state, drops
//   any pending record and restores the threshold to 0.3. End of stream
//   clears the scene state but keeps the threshold.
// ============================================================================
module video_scene_cut_detector_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // threshold register write
    input  logic                          cfg_we,
    input  logic [vscd_pkg::THR_W-1:0]    cfg_wdata,
    // frame records
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vscd_pkg::IN_W-1:0]     s_tdata,  // frame_size, frame_pts, frame_time_us
    input  logic                          s_tuser,  // key_frame
    input  logic                          s_tlast,  // end_of_stream
    // scene records
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vscd_pkg::OUT_W-1:0]    m_tdata,  // scene_number, first_frame, final_frame,
                                                    // start_pts, end_pts, start_time_us,
                                                    // end_time_us, frames_in_scene,
                                                    // mean_size_q8, pad
    output logic                          m_tuser,  // stream_done
    output logic                          m_tlast   // run_last
);
    import vscd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_TAIL = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    localparam int LHS_W = SIZE_W + 16;
    localparam int RHS_W = THR_W + SIZE_W;

    logic [2:0]          state_reg, state_next;
    logic [THR_W-1:0]    thr_reg;

    in_data_t            in_reg;
    logic                in_key_reg;
    logic                in_eos_reg;

    logic                have_prev_reg;
    logic [SIZE_W-1:0]   prev_size_reg;
    logic [PTS_W-1:0]    prev_pts_reg;
    logic [TIME_W-1:0]   prev_time_reg;
    logic [FRAME_W-1:0]  frame_cnt_reg;
    logic [SCENE_W-1:0]  scene_cnt_reg;
    logic [FRAME_W-1:0]  first_frame_reg;
    logic [PTS_W-1:0]    first_pts_reg;
    logic [TIME_W-1:0]   first_time_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic [LHS_W-1:0]    lhs_reg;
    logic [RHS_W-1:0]    rhs_reg;

    scene_rec_t          rec_reg;
    logic                rec_done_reg;
    logic                rec_last_reg;

    logic                m_valid_reg;
    scene_rec_t          m_data_reg;
    logic                m_user_reg;
    logic                m_last_reg;

    in_data_t            s_data;
    logic [SIZE_W-1:0]   abs_diff;
    logic [RHS_W-1:0]    product;
    logic                cut;
    logic [FRAME_W-1:0]  cut_last;
    logic [FRAME_W-1:0]  last_sel;
    logic [SUM_W:0]      sum_add;
    logic                out_free;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [MEAN_W-1:0]   div_quot;
    scene_rec_t          rec_new;
    scene_rec_t          rec_out;

    assign s_data = in_data_t'(s_tdata);

    // Size change compare and scene bookkeeping terms
    always_comb begin
        abs_diff = (in_reg.frame_size >= prev_size_reg) ?
                   in_reg.frame_size - prev_size_reg : prev_size_reg - in_reg.frame_size;
        product  = RHS_W'(thr_reg) * RHS_W'(prev_size_reg);
        cut      = have_prev_reg && (prev_size_reg != '0) &&
                   ((in_key_reg && ({(RHS_W-LHS_W+1)'(0), lhs_reg} > {1'b0, rhs_reg})) ||
                    ({(RHS_W-LHS_W+1)'(0), lhs_reg} > {rhs_reg, 1'b0}));

        // Last frame of the scene closed by a cut
        cut_last = (frame_cnt_reg == '0) ? '0 : frame_cnt_reg - FRAME_W'(1);
        if (frame_cnt_reg == FRAME_MAX && first_frame_reg == FRAME_MAX) begin
            cut_last = FRAME_MAX;
        end
        if (cut_last < first_frame_reg) begin
            cut_last = first_frame_reg;
        end

        last_sel = (state_reg == ST_CMP) ? cut_last : frame_cnt_reg;
        sum_add  = {1'b0, sum_reg} + (SUM_W+1)'(in_reg.frame_size);
        out_free = !m_valid_reg || m_tready;
    end

    // Assemble the scene record for the divider pass
    always_comb begin
        rec_new                 = '0;
        rec_new.scene_number    = scene_cnt_reg;
        rec_new.first_frame     = first_frame_reg;
        rec_new.final_frame     = last_sel;
        rec_new.start_pts       = first_pts_reg;
        rec_new.start_time_us   = first_time_reg;
        rec_new.frames_in_scene = scene_count(last_sel, first_frame_reg);
        if (state_reg == ST_CMP) begin
            rec_new.end_pts     = prev_pts_reg;
            rec_new.end_time_us = prev_time_reg;
        end else begin
            rec_new.end_pts     = in_reg.frame_pts;
            rec_new.end_time_us = in_reg.frame_time_us;
        end
        rec_out              = rec_reg;
        rec_out.mean_size_q8 = div_quot;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (cut) begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (in_eos_reg) begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) state_next = rec_done_reg ? ST_IDLE : ST_TAIL;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, scene state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            thr_reg         <= THR_RESET;
            have_prev_reg   <= 1'b0;
            prev_size_reg   <= '0;
            prev_pts_reg    <= '0;
            prev_time_reg   <= '0;
            frame_cnt_reg   <= '0;
            scene_cnt_reg   <= '0;
            first_frame_reg <= '0;
            first_pts_reg   <= '0;
            first_time_reg  <= '0;
            sum_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) thr_reg <= cfg_wdata;

            // Raise valid on a record push, drop it once the receiver takes it
            if (state_reg == ST_PUSH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CMP: begin
                    // Open a scene on the first frame or on a cut, else accumulate
                    if (!have_prev_reg || cut) begin
                        first_frame_reg <= frame_cnt_reg;
                        first_pts_reg   <= in_reg.frame_pts;
                        first_time_reg  <= in_reg.frame_time_us;
                        sum_reg         <= SUM_W'(in_reg.frame_size);
                        if (cut && scene_cnt_reg != SCENE_MAX) begin
                            scene_cnt_reg <= scene_cnt_reg + SCENE_W'(1);
                        end
                    end else begin
                        sum_reg <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    end
                end
                ST_TAIL: begin
                    if (in_eos_reg) begin
                        // Clear the stream once the final record is captured
                        have_prev_reg   <= 1'b0;
                        prev_size_reg   <= '0;
                        prev_pts_reg    <= '0;
                        prev_time_reg   <= '0;
                        frame_cnt_reg   <= '0;
                        scene_cnt_reg   <= '0;
                        first_frame_reg <= '0;
                        first_pts_reg   <= '0;
                        first_time_reg  <= '0;
                        sum_reg         <= '0;
                    end else begin
                        have_prev_reg <= 1'b1;
                        prev_size_reg <= in_reg.frame_size;
                        prev_pts_reg  <= in_reg.frame_pts;
                        prev_time_reg <= in_reg.frame_time_us;
                        if (frame_cnt_reg != FRAME_MAX) begin
                            frame_cnt_reg <= frame_cnt_reg + FRAME_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            in_reg     <= s_data;
            in_key_reg <= s_tuser;
            in_eos_reg <= s_tlast;
        end
        if (state_reg == ST_MUL) begin
            lhs_reg <= {abs_diff, 16'd0};
            rhs_reg <= product;
        end
        if (div_start) begin
            rec_reg      <= rec_new;
            rec_done_reg <= (state_reg == ST_TAIL);
            rec_last_reg <= (state_reg == ST_TAIL) || !in_eos_reg;
        end
        if (state_reg == ST_PUSH && out_free) begin
            m_data_reg <= rec_out;
            m_user_reg <= rec_done_reg;
            m_last_reg <= rec_last_reg;
        end
    end

    vscd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_reg, FRAC_W'(0)}),
        .divisor  (rec_new.frames_in_scene),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider running outside its sequencer state");

    a_accept_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_MUL)
        else $error("accepted transfer did not start the compare");

    a_fresh_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_prev_reg |-> frame_cnt_reg == '0)
        else $error("frame counter set with no previous frame");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.frames_in_scene != '0)
        else $error("scene record with zero frames");

endmodule
